@@ hw/rtl/hcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   localparam int SIZE_BITS      = 32;
   localparam int BYTE_BITS      = 8;
   localparam int LINE_CNT_BITS  = 8;

   localparam logic [LINE_CNT_BITS-1:0] MAX_LINE_RESET = 8'd64;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_LINE_LONG = 2'd0,
      ERR_NO_DIGITS = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_CLOSED    = 2'd3
   } err_type;

   typedef struct packed {
      kind_type             kind;
      logic [BYTE_BITS-1:0] data_byte;
      logic                 chunk_last;
      err_type              error_code;
   } rsp_item_type;

endpackage

@@ hw/rtl/hcbd_req_if.sv @@
// ----------------------------------------------------------------------------
// hcbd_req_if
// Input channel: one body byte or a close event per item.
// ----------------------------------------------------------------------------
interface hcbd_req_if;
   import hcbd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [BYTE_BITS-1:0] in_byte;

   modport source (output valid, output action, output in_byte, input ready);
   modport sink   (input valid, input action, input in_byte, output ready);
endinterface

@@ hw/rtl/hcbd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// hcbd_rsp_if
// Result channel: payload byte, completion or error per item.
// ----------------------------------------------------------------------------
interface hcbd_rsp_if;
   import hcbd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   logic [BYTE_BITS-1:0] data_byte;
   logic                 chunk_last;
   logic [1:0]           error_code;

   modport source (output valid, output kind, output data_byte, output chunk_last,
                   output error_code, input ready);
   modport sink   (input valid, input kind, input data_byte, input chunk_last,
                   input error_code, output ready);
endinterface

@@ hw/rtl/hcbd_core.sv @@
// ----------------------------------------------------------------------------
// hcbd_core
// Decoder state and the combinational update for one item.
// ----------------------------------------------------------------------------
module hcbd_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 go,
   input  logic                                 action,
   input  logic [hcbd_pkg::BYTE_BITS-1:0]       in_byte,
   input  logic [hcbd_pkg::LINE_CNT_BITS-1:0]   max_line,
   output logic                                 res_valid,
   output hcbd_pkg::rsp_item_type               res_item
);
   import hcbd_pkg::*;

   localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0d;
   localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0a;
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;

   typedef enum logic [2:0] {
      PH_LINE     = 3'd0,
      PH_DATA     = 3'd1,
      PH_SKIP     = 3'd2,
      PH_SKIP_END = 3'd3,
      PH_DONE     = 3'd4,
      PH_ERROR    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      DS_BLANKS = 2'd0,
      DS_DIGITS = 2'd1,
      DS_ENDED  = 2'd2,
      DS_NONE   = 2'd3
   } stage_type;

   typedef struct packed {
      stage_type            stage;
      logic [SIZE_BITS-1:0] accum;
      logic                 ovf;
   } feed_type;

   phase_type                phase_ff, phase_in;
   logic [SIZE_BITS-1:0]     rem_ff, rem_in;
   logic [SIZE_BITS-1:0]     accum_ff, accum_in;
   logic [LINE_CNT_BITS-1:0] count_ff, count_in;
   logic                     cr_ff, cr_in;
   stage_type                stage_ff, stage_in;
   logic                     skip_ff, skip_in;

   logic [LINE_CNT_BITS:0]   content;
   logic                     is_cr;
   logic                     last;
   feed_type                 feed_cr;
   feed_type                 feed_b;

   // {is_hex, value}
   function automatic logic [4:0] hex_decode(logic [BYTE_BITS-1:0] b);
      logic [4:0] r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   function automatic feed_type digit_feed(feed_type cur, logic [BYTE_BITS-1:0] b);
      feed_type   r;
      logic [4:0] h;
      logic       take;
      r    = cur;
      h    = hex_decode(b);
      take = 1'b0;
      unique case (cur.stage)
         DS_BLANKS: begin
            if (!(b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR))) begin
               r.stage = h[4] ? DS_DIGITS : DS_NONE;
               take    = h[4];
            end
         end
         DS_DIGITS: begin
            if (h[4]) begin
               take = 1'b1;
            end else begin
               r.stage = DS_ENDED;
            end
         end
         default: begin
         end
      endcase
      if (take) begin
         if (cur.accum[SIZE_BITS-1 -: 4] != 4'd0) begin
            r.ovf = 1'b1;
         end else begin
            r.accum = {cur.accum[SIZE_BITS-5:0], h[3:0]};
         end
      end
      return r;
   endfunction

   assign is_cr   = (in_byte == CHAR_CR);
   assign content = {1'b0, count_ff} + {{LINE_CNT_BITS{1'b0}}, cr_ff}
                    + {{LINE_CNT_BITS{1'b0}}, !is_cr};
   assign last    = (rem_ff <= SIZE_BITS'(1));

   // a pending cr that turned out not to start the terminator is a blank content byte
   always_comb begin
      feed_cr = '{stage: stage_ff, accum: accum_ff, ovf: 1'b0};
      if (cr_ff && stage_ff == DS_DIGITS) begin
         feed_cr.stage = DS_ENDED;
      end
      feed_b = is_cr ? feed_cr : digit_feed(feed_cr, in_byte);
   end

   always_comb begin
      phase_in  = phase_ff;
      rem_in    = rem_ff;
      accum_in  = accum_ff;
      count_in  = count_ff;
      cr_in     = cr_ff;
      stage_in  = stage_ff;
      skip_in   = skip_ff;
      res_valid = 1'b0;
      res_item  = '{kind: KIND_DATA, data_byte: '0, chunk_last: 1'b0,
                    error_code: ERR_LINE_LONG};

      if (go && phase_ff != PH_ERROR && phase_ff != PH_DONE) begin
         if (action) begin
            phase_in            = PH_ERROR;
            res_valid           = 1'b1;
            res_item.kind       = KIND_ERROR;
            res_item.error_code = ERR_CLOSED;
         end else begin
            unique case (phase_ff)
               PH_LINE: begin
                  if (cr_ff && in_byte == CHAR_LF) begin
                     if (stage_ff == DS_BLANKS || stage_ff == DS_NONE) begin
                        phase_in            = PH_ERROR;
                        res_valid           = 1'b1;
                        res_item.kind       = KIND_ERROR;
                        res_item.error_code = ERR_NO_DIGITS;
                     end else begin
                        skip_in = 1'b0;
                        if (accum_ff == '0) begin
                           phase_in = PH_SKIP_END;
                        end else begin
                           rem_in   = accum_ff;
                           phase_in = PH_DATA;
                        end
                        accum_in = '0;
                        count_in = '0;
                        cr_in    = 1'b0;
                        stage_in = DS_BLANKS;
                     end
                  end else if (content > {1'b0, max_line}) begin
                     phase_in            = PH_ERROR;
                     res_valid           = 1'b1;
                     res_item.kind       = KIND_ERROR;
                     res_item.error_code = ERR_LINE_LONG;
                  end else if (feed_b.ovf) begin
                     phase_in            = PH_ERROR;
                     res_valid           = 1'b1;
                     res_item.kind       = KIND_ERROR;
                     res_item.error_code = ERR_OVERFLOW;
                  end else begin
                     count_in = content[LINE_CNT_BITS-1:0];
                     cr_in    = is_cr;
                     stage_in = feed_b.stage;
                     accum_in = feed_b.accum;
                  end
               end
               PH_DATA: begin
                  res_valid           = 1'b1;
                  res_item.kind       = KIND_DATA;
                  res_item.data_byte  = in_byte;
                  res_item.chunk_last = last;
                  if (last) begin
                     rem_in   = '0;
                     phase_in = PH_SKIP;
                     skip_in  = 1'b0;
                  end else begin
                     rem_in = rem_ff - SIZE_BITS'(1);
                  end
               end
               PH_SKIP: begin
                  if (!skip_ff) begin
                     skip_in = 1'b1;
                  end else begin
                     skip_in  = 1'b0;
                     accum_in = '0;
                     count_in = '0;
                     cr_in    = 1'b0;
                     stage_in = DS_BLANKS;
                     phase_in = PH_LINE;
                  end
               end
               PH_SKIP_END: begin
                  if (!skip_ff) begin
                     skip_in = 1'b1;
                  end else begin
                     skip_in       = 1'b0;
                     phase_in      = PH_DONE;
                     res_valid     = 1'b1;
                     res_item.kind = KIND_DONE;
                  end
               end
               default: begin
                  phase_in = PH_ERROR;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LINE;
         rem_ff   <= '0;
         accum_ff <= '0;
         count_ff <= '0;
         cr_ff    <= 1'b0;
         stage_ff <= DS_BLANKS;
         skip_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         accum_ff <= accum_in;
         count_ff <= count_in;
         cr_ff    <= cr_in;
         stage_ff <= stage_in;
         skip_ff  <= skip_in;
      end
   end

`ifndef SYNTHESIS
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |=> phase_ff == PH_ERROR)
      else $error("decoder left the error phase");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |=> phase_ff == PH_DONE)
      else $error("decoder left the complete phase");

   a_result_needs_item: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> go)
      else $error("result produced without an item");

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> rem_ff != '0)
      else $error("data phase with no bytes left");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_item.kind == KIND_ERROR |=> phase_ff == PH_ERROR)
      else $error("error reported but not latched");
`endif

endmodule

@@ hw/rtl/http_chunked_body_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Byte-serial chunked body decoder: strips size lines, passes payload bytes,
// reports completion or a latched error.
// ----------------------------------------------------------------------------
//   channel  dir  handshake         payload
//   req      in   valid / ready     action, in_byte
//   rsp      out  valid / ready     kind, data_byte, chunk_last, error_code
//   csr      in   csr_wr_en         csr_wr_data (max_line)
//
// one item per cycle sustained while rsp takes each result; an item's result, if it
// has one, passes through the input register, then the decoder update into the
// output register, before it is valid on rsp
// reset (synchronous) clears the decoder to the size line phase and max_line to 64
// req.ready drops only when the input register holds an item and the output
// register holds a result that rsp does not take
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [hcbd_pkg::LINE_CNT_BITS-1:0] csr_wr_data,
   hcbd_req_if.sink                           req,
   hcbd_rsp_if.source                         rsp
);
   import hcbd_pkg::*;

   logic [LINE_CNT_BITS-1:0] max_line_ff, max_line_in;

   logic                     in_valid_ff, in_valid_in;
   logic                     in_action_ff, in_action_in;
   logic [BYTE_BITS-1:0]     in_byte_ff, in_byte_in;

   logic                     out_valid_ff, out_valid_in;
   rsp_item_type             out_item_ff, out_item_in;

   logic                     go;
   logic                     req_fire;
   logic                     res_valid;
   rsp_item_type             res_item;

   // input item moves on when the output register is free or draining
   assign go        = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || go;
   assign req_fire  = req.valid && req.ready;

   hcbd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .action    (in_action_ff),
      .in_byte   (in_byte_ff),
      .max_line  (max_line_ff),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   always_comb begin
      max_line_in  = csr_wr_en ? csr_wr_data : max_line_ff;

      in_valid_in  = req_fire || (in_valid_ff && !go);
      in_action_in = req_fire ? req.action  : in_action_ff;
      in_byte_in   = req_fire ? req.in_byte : in_byte_ff;

      out_valid_in = res_valid || (out_valid_ff && !rsp.ready);
      out_item_in  = res_valid ? res_item : out_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff  <= MAX_LINE_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         max_line_ff  <= max_line_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_action_ff <= in_action_in;
      in_byte_ff   <= in_byte_in;
      out_item_ff  <= out_item_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.kind       = out_item_ff.kind;
   assign rsp.data_byte  = out_item_ff.data_byte;
   assign rsp.chunk_last = out_item_ff.chunk_last;
   assign rsp.error_code = out_item_ff.error_code;

endmodule
